[rtl/set_assoc_writeback_lru_cache_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative write-back cache
// Clocked on clk; the reset variant is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_WRITEBACK_LRU_CACHE_TOP_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_LRU_CACHE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define SAWLC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define SAWLC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SAWLC_ASSERT(lbl, prop, msg)
`define SAWLC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/sawlc_pkg.sv]
// ----------------------------------------------------------------------------
// sawlc_pkg
// Types and constants of the set-associative write-back LRU cache.
// ----------------------------------------------------------------------------
package sawlc_pkg;

	localparam int MAX_LINES       = 64;
	localparam int LINE_W          = $clog2(MAX_LINES);
	localparam int MAX_BLOCK_WORDS = 16;
	localparam int OFF_W           = $clog2(MAX_BLOCK_WORDS);
	localparam int MEM_WORDS       = 65536;
	localparam int MEM_AW          = $clog2(MEM_WORDS);
	localparam int LW_DEPTH        = MAX_LINES * MAX_BLOCK_WORDS;
	localparam int LW_AW           = LINE_W + OFF_W;

	localparam logic [1:0] KIND_LOAD    = 2'd0;
	localparam logic [1:0] KIND_STORE   = 2'd1;
	localparam logic [1:0] KIND_PRELOAD = 2'd2;

	localparam logic [2:0] ACT_C2P  = 3'd0;
	localparam logic [2:0] ACT_P2C  = 3'd1;
	localparam logic [2:0] ACT_FILL = 3'd2;
	localparam logic [2:0] ACT_WB   = 3'd3;
	localparam logic [2:0] ACT_DROP = 3'd4;

	localparam logic [1:0] CFG_LOG2_BLOCK_WORDS = 2'd0;
	localparam logic [1:0] CFG_LOG2_SETS        = 2'd1;
	localparam logic [1:0] CFG_WAYS             = 2'd2;

	typedef struct packed {
		logic [1:0]         kind;
		logic [15:0]        word_address;
		logic signed [31:0] store_data;
	} in_t;

	typedef struct packed {
		logic [2:0]         action;
		logic [15:0]        start_address;
		logic [4:0]         word_count;
		logic signed [31:0] load_data;
		logic               last;
	} out_t;

endpackage

[rtl/sawlc_ram.sv]
// ----------------------------------------------------------------------------
// sawlc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sawlc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/set_assoc_writeback_lru_cache_top.sv]
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache_top
// Word-addressed set-associative write-back write-allocate cache, true LRU.
// ----------------------------------------------------------------------------
// After reset the block sweeps the backing memory to zero, one word a cycle,
// and holds in_stall high meanwhile (config writes are taken). One sequencer
// walks the ways of a set through the tag and age RAMs one way a cycle. A
// hit goes through accept, tag scan, decide, age update, finish and word
// transfer (with an extra read step for a load); a miss adds the fill, plus
// the writeback on a dirty victim, plus an eviction report when a way is
// replaced and a fill report. A preload or unused kind is finished in the
// accept state. Any report waits while the output register is still held by
// a stalled transaction. The sustained rate is set by the single shared
// way/word loop and the single write port of each memory. Results leave
// through one output register.
module set_assoc_writeback_lru_cache_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sawlc_pkg::in_t    in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output sawlc_pkg::out_t   out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data
);

	`include "set_assoc_writeback_lru_cache_top_assert.svh"

	localparam int LW  = sawlc_pkg::LINE_W;
	localparam int OW  = sawlc_pkg::OFF_W;
	localparam int MAW = sawlc_pkg::MEM_AW;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SCAN, S_DECIDE, S_WB, S_EV_OUT, S_FILL,
		S_AGE, S_FIN, S_FILL_OUT, S_WORD, S_LOAD, S_WORD_OUT
	} state_t;

	state_t            state_q;
	logic [MAW-1:0]    clr_q;
	logic [2:0]        lb_q, ls_q;
	logic [6:0]        ways_q;
	logic [sawlc_pkg::MAX_LINES-1:0] valid_q, dirty_q;

	logic [1:0]        kind_q;
	logic [15:0]       a_q, blk_q, tag_q, ev_q;
	logic [31:0]       data_q, load_q;
	logic [OW-1:0]     off_q;
	logic [LW-1:0]     set_q, base_q, line_q;
	logic [6:0]        cnt_q;
	logic              pv_s1;
	logic [LW-1:0]     pidx_s1;
	logic              hit_q, empty_q, miss_q, ev_dirty_q;
	logic [LW-1:0]     hit_line_q, empty_line_q, vic_line_q;
	logic [5:0]        hit_age_q, vic_age_q;
	logic [15:0]       vic_tag_q;
	logic              out_valid_q;
	sawlc_pkg::out_t   out_q;

	// memory ports
	logic              bm_we, lw_we, tag_we, age_we;
	logic [MAW-1:0]    bm_waddr, bm_raddr;
	logic [31:0]       bm_wdata, bm_rdata, lw_wdata, lw_rdata;
	logic [sawlc_pkg::LW_AW-1:0] lw_waddr, lw_raddr;
	logic [LW-1:0]     tag_waddr, age_waddr, way_raddr;
	logic [15:0]       tag_wdata, tag_rdata;
	logic [5:0]        age_wdata, age_rdata;

	// decode of the incoming address
	logic [15:0]       off_mask, set_mask, in_off, in_set, in_tag;
	logic [12:0]       in_base;
	logic [4:0]        bw;
	logic [6:0]        loop_lim;
	logic              issue, loop_done, out_free;
	logic [LW-1:0]     p_line;
	logic              p_valid, age_cond;
	logic [15:0]       ev_tmp;
	logic [2:0]        cand_lb, cand_ls;
	logic [6:0]        cand_w;
	logic [13:0]       cand_prod;
	logic              cand_idx_ok;
	logic              cand_ok;

	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_CLEAR);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign off_mask = (16'd1 << lb_q) - 16'd1;
	assign set_mask = (16'd1 << ls_q) - 16'd1;
	assign in_off   = in_data.word_address & off_mask;
	assign in_set   = (in_data.word_address >> lb_q) & set_mask;
	assign in_tag   = in_data.word_address >> ({1'b0, lb_q} + {1'b0, ls_q});
	assign in_base  = 13'(in_set[LW-1:0]) * 13'(ways_q);
	assign bw       = 5'(5'd1 << lb_q);

	assign loop_lim  = (state_q == S_WB || state_q == S_FILL) ? {2'b0, bw} : ways_q;
	assign issue     = (cnt_q < loop_lim);
	assign loop_done = !issue && !pv_s1;
	assign way_raddr = LW'(7'(base_q) + cnt_q);
	assign p_line    = LW'(7'(base_q) + 7'(pidx_s1));
	assign p_valid   = valid_q[p_line];
	assign age_cond  = (p_line != line_q) && p_valid && (miss_q || (age_rdata < hit_age_q));
	assign ev_tmp    = (vic_tag_q << ls_q) | 16'(set_q);

	// config legality
	always_comb begin
		cand_lb     = lb_q;
		cand_ls     = ls_q;
		cand_w      = ways_q;
		cand_idx_ok = 1'b1;
		case (cfg_index)
			sawlc_pkg::CFG_LOG2_BLOCK_WORDS: cand_lb = cfg_data[2:0];
			sawlc_pkg::CFG_LOG2_SETS:        cand_ls = cfg_data[2:0];
			sawlc_pkg::CFG_WAYS:             cand_w  = cfg_data;
			default:                         cand_idx_ok = 1'b0;
		endcase
		cand_prod = 14'(cand_w) << cand_ls;
		cand_ok = cand_idx_ok && (cand_lb <= 3'd4) && (cand_ls <= 3'd6) &&
			(cand_w != 7'd0) && (cand_w <= 7'd64) && (cand_prod <= 14'd64);
	end

	// memory control
	always_comb begin
		bm_we     = 1'b0;
		bm_waddr  = clr_q;
		bm_wdata  = 32'd0;
		bm_raddr  = blk_q + 16'(cnt_q);
		lw_we     = 1'b0;
		lw_waddr  = {line_q, off_q};
		lw_wdata  = data_q;
		lw_raddr  = (state_q == S_WB) ? {line_q, cnt_q[OW-1:0]} : {line_q, off_q};
		tag_we    = 1'b0;
		tag_waddr = line_q;
		tag_wdata = tag_q;
		age_we    = 1'b0;
		age_waddr = p_line;
		age_wdata = age_rdata + 6'd1;
		case (state_q)
			S_CLEAR: bm_we = 1'b1;
			S_IDLE: begin
				if (in_valid && in_data.kind == sawlc_pkg::KIND_PRELOAD) begin
					bm_we    = 1'b1;
					bm_waddr = in_data.word_address;
					bm_wdata = in_data.store_data;
				end
			end
			S_WB: begin
				bm_we    = pv_s1;
				bm_waddr = ev_q + 16'(pidx_s1);
				bm_wdata = lw_rdata;
			end
			S_FILL: begin
				lw_we    = pv_s1;
				lw_waddr = {line_q, pidx_s1[OW-1:0]};
				lw_wdata = bm_rdata;
			end
			S_AGE: age_we = pv_s1 && age_cond;
			S_FIN: begin
				age_we    = 1'b1;
				age_waddr = line_q;
				age_wdata = 6'd0;
				tag_we    = miss_q;
			end
			S_WORD: lw_we = (kind_q == sawlc_pkg::KIND_STORE);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			lb_q        <= 3'd0;
			ls_q        <= 3'd0;
			ways_q      <= 7'd1;
			valid_q     <= '0;
			dirty_q     <= '0;
			cnt_q       <= '0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready && cand_ok) begin
				lb_q    <= cand_lb;
				ls_q    <= cand_ls;
				ways_q  <= cand_w;
				valid_q <= '0;
				dirty_q <= '0;
			end
			// shared way/word loop; the count restarts for a following loop phase
			if (state_q == S_SCAN || state_q == S_WB || state_q == S_FILL ||
					state_q == S_AGE) begin
				pv_s1   <= issue;
				pidx_s1 <= cnt_q[LW-1:0];
				if (issue) begin
					cnt_q <= cnt_q + 7'd1;
				end else if (loop_done) begin
					cnt_q <= '0;
				end
			end else begin
				pv_s1 <= 1'b0;
				cnt_q <= '0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						kind_q     <= in_data.kind;
						a_q        <= in_data.word_address;
						data_q     <= in_data.store_data;
						off_q      <= in_off[OW-1:0];
						set_q      <= in_set[LW-1:0];
						tag_q      <= in_tag;
						blk_q      <= in_data.word_address & ~off_mask;
						base_q     <= in_base[LW-1:0];
						vic_line_q <= in_base[LW-1:0];
						vic_age_q  <= 6'd0;
						hit_q      <= 1'b0;
						empty_q    <= 1'b0;
						if (in_data.kind == sawlc_pkg::KIND_LOAD ||
								in_data.kind == sawlc_pkg::KIND_STORE) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (pv_s1) begin
						if (p_valid && tag_rdata == tag_q) begin
							hit_q      <= 1'b1;
							hit_line_q <= p_line;
							hit_age_q  <= age_rdata;
						end
						if (!p_valid && !empty_q) begin
							empty_q      <= 1'b1;
							empty_line_q <= p_line;
						end
						if (p_valid && age_rdata >= vic_age_q) begin
							vic_line_q <= p_line;
							vic_age_q  <= age_rdata;
							vic_tag_q  <= tag_rdata;
						end
					end
					if (loop_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (hit_q) begin
						miss_q  <= 1'b0;
						line_q  <= hit_line_q;
						state_q <= S_AGE;
					end else if (empty_q) begin
						miss_q  <= 1'b1;
						line_q  <= empty_line_q;
						state_q <= S_FILL;
					end else begin
						miss_q     <= 1'b1;
						line_q     <= vic_line_q;
						ev_q       <= ev_tmp << lb_q;
						ev_dirty_q <= dirty_q[vic_line_q];
						state_q    <= dirty_q[vic_line_q] ? S_WB : S_EV_OUT;
					end
				end
				S_WB: begin
					if (loop_done) begin
						state_q <= S_EV_OUT;
					end
				end
				S_EV_OUT: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.action        <= ev_dirty_q ? sawlc_pkg::ACT_WB :
							sawlc_pkg::ACT_DROP;
						out_q.start_address <= ev_q;
						out_q.word_count    <= bw;
						out_q.load_data     <= '0;
						out_q.last          <= 1'b0;
						state_q             <= S_FILL;
					end
				end
				S_FILL: begin
					if (loop_done) begin
						state_q <= S_AGE;
					end
				end
				S_AGE: begin
					if (loop_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (miss_q) begin
						valid_q[line_q] <= 1'b1;
						dirty_q[line_q] <= 1'b0;
						state_q         <= S_FILL_OUT;
					end else begin
						state_q <= S_WORD;
					end
				end
				S_FILL_OUT: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.action        <= sawlc_pkg::ACT_FILL;
						out_q.start_address <= blk_q;
						out_q.word_count    <= bw;
						out_q.load_data     <= '0;
						out_q.last          <= 1'b0;
						state_q             <= S_WORD;
					end
				end
				S_WORD: begin
					if (kind_q == sawlc_pkg::KIND_STORE) begin
						dirty_q[line_q] <= 1'b1;
						load_q          <= 32'd0;
						state_q         <= S_WORD_OUT;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					load_q  <= lw_rdata;
					state_q <= S_WORD_OUT;
				end
				S_WORD_OUT: begin
					if (out_free) begin
						out_valid_q         <= 1'b1;
						out_q.action        <= (kind_q == sawlc_pkg::KIND_STORE) ?
							sawlc_pkg::ACT_P2C : sawlc_pkg::ACT_C2P;
						out_q.start_address <= a_q;
						out_q.word_count    <= 5'd1;
						out_q.load_data     <= load_q;
						out_q.last          <= 1'b1;
						state_q             <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	sawlc_ram #(.WIDTH(32), .DEPTH(sawlc_pkg::MEM_WORDS)) u_backing (
		.clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
		.raddr(bm_raddr), .rdata(bm_rdata)
	);

	sawlc_ram #(.WIDTH(32), .DEPTH(sawlc_pkg::LW_DEPTH)) u_words (
		.clk(clk), .we(lw_we), .waddr(lw_waddr), .wdata(lw_wdata),
		.raddr(lw_raddr), .rdata(lw_rdata)
	);

	sawlc_ram #(.WIDTH(16), .DEPTH(sawlc_pkg::MAX_LINES)) u_tags (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
		.raddr(way_raddr), .rdata(tag_rdata)
	);

	sawlc_ram #(.WIDTH(6), .DEPTH(sawlc_pkg::MAX_LINES)) u_ages (
		.clk(clk), .we(age_we), .waddr(age_waddr), .wdata(age_wdata),
		.raddr(way_raddr), .rdata(age_rdata)
	);

	`SAWLC_ASSERT(a_dirty_valid, (dirty_q & ~valid_q) == '0, "dirty line not valid")
	`SAWLC_ASSERT(a_cfg_legal, (ways_q != 7'd0) && ((14'(ways_q) << ls_q) <= 14'd64) && (lb_q <= 3'd4), "illegal geometry")
	`SAWLC_ASSERT(a_fill_not_last, (out_valid_q && out_q.action == sawlc_pkg::ACT_FILL) |-> !out_q.last, "fill report marked last")
	`SAWLC_ASSERT(a_last_one_word, (out_valid_q && out_q.last) |-> (out_q.word_count == 5'd1), "word transfer count")

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the set-associative write-back LRU cache.
// A behavioral cache model predicts every eviction, fill and word report
// for each accepted access. A checker compares each output transaction
// field by field with the oldest prediction. Input gaps and output stalls
// are random, and the block runs under several geometries.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sawlc_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sawlc_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	set_assoc_writeback_lru_cache_top u_top (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.out_valid, .out_stall, .out_data,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always #5 clk = ~clk;

	// cache model state
	int unsigned blk_log2, set_log2, n_ways;
	bit line_vld [sawlc_pkg::MAX_LINES];
	bit line_drt [sawlc_pkg::MAX_LINES];
	bit [5:0] line_lru [sawlc_pkg::MAX_LINES];
	bit [15:0] line_tg [sawlc_pkg::MAX_LINES];
	bit [31:0] line_dat [sawlc_pkg::LW_DEPTH];
	bit [31:0] mem_img [sawlc_pkg::MEM_WORDS];

	sawlc_pkg::out_t report_q[$];
	int errors = 0;
	int cycles = 0;

	function automatic void invalidate_lines();
		for (int i = 0; i < sawlc_pkg::MAX_LINES; i++) begin
			line_vld[i] = 0;
			line_drt[i] = 0;
			line_lru[i] = 0;
		end
	endfunction

	function automatic void push_report(logic [2:0] act, bit [15:0] addr, int unsigned cnt,
			bit [31:0] dat, bit lst);
		sawlc_pkg::out_t r;
		r.action = act;
		r.start_address = addr;
		r.word_count = cnt[4:0];
		r.load_data = dat;
		r.last = lst;
		report_q.push_back(r);
	endfunction

	function automatic void apply_cfg(logic [1:0] idx, logic [6:0] val);
		int unsigned lb, ls, w;
		lb = blk_log2;
		ls = set_log2;
		w = n_ways;
		case (idx)
			sawlc_pkg::CFG_LOG2_BLOCK_WORDS: lb = 32'(val[2:0]);
			sawlc_pkg::CFG_LOG2_SETS: ls = 32'(val[2:0]);
			sawlc_pkg::CFG_WAYS: w = 32'(val);
			default: return;
		endcase
		if (lb > 4 || ls > 6 || w < 1 || w > 64) return;
		if ((1 << ls) * w > sawlc_pkg::MAX_LINES) return;
		blk_log2 = lb;
		set_log2 = ls;
		n_ways = w;
		invalidate_lines();
	endfunction

	function automatic void predict_access(sawlc_pkg::in_t it);
		int unsigned bw, off, set, tg, base, ln, ev, blk;
		int hit, empty;
		bit [5:0] old;
		hit = -1;
		empty = -1;
		if (it.kind == sawlc_pkg::KIND_PRELOAD) begin
			mem_img[it.word_address] = it.store_data;
			return;
		end
		if (it.kind != sawlc_pkg::KIND_LOAD && it.kind != sawlc_pkg::KIND_STORE) return;
		bw = 1 << blk_log2;
		off = it.word_address & (bw - 1);
		set = (it.word_address >> blk_log2) & ((1 << set_log2) - 1);
		tg = it.word_address >> (blk_log2 + set_log2);
		base = set * n_ways;
		for (int i = 0; i < n_ways; i++) begin
			if (line_vld[base + i] && line_tg[base + i] == tg) hit = base + i;
			if (!line_vld[base + i] && empty < 0) empty = base + i;
		end
		if (hit >= 0) begin
			ln = hit;
			old = line_lru[ln];
			for (int i = 0; i < n_ways; i++)
				if (base + i != ln && line_vld[base + i] && line_lru[base + i] < old)
					line_lru[base + i]++;
			line_lru[ln] = 0;
		end else begin
			if (empty >= 0) begin
				ln = empty;
			end else begin
				// oldest valid way, ties go to the highest way
				ln = base;
				for (int i = 0; i < n_ways; i++)
					if (line_vld[base + i] && line_lru[base + i] >= line_lru[ln]) ln = base + i;
				ev = ((line_tg[ln] << set_log2) | set) << blk_log2;
				ev &= 16'hFFFF;
				if (line_drt[ln]) begin
					for (int i = 0; i < bw; i++)
						mem_img[(ev + i) % sawlc_pkg::MEM_WORDS] =
							line_dat[ln * sawlc_pkg::MAX_BLOCK_WORDS + i];
					push_report(sawlc_pkg::ACT_WB, 16'(ev), bw, 0, 0);
				end else begin
					push_report(sawlc_pkg::ACT_DROP, 16'(ev), bw, 0, 0);
				end
			end
			blk = it.word_address - off;
			for (int i = 0; i < bw; i++)
				line_dat[ln * sawlc_pkg::MAX_BLOCK_WORDS + i] =
					mem_img[(blk + i) % sawlc_pkg::MEM_WORDS];
			for (int i = 0; i < n_ways; i++)
				if (base + i != ln && line_vld[base + i]) line_lru[base + i]++;
			line_vld[ln] = 1;
			line_drt[ln] = 0;
			line_lru[ln] = 0;
			line_tg[ln] = 16'(tg);
			push_report(sawlc_pkg::ACT_FILL, 16'(blk), bw, 0, 0);
		end
		if (it.kind == sawlc_pkg::KIND_LOAD) begin
			push_report(sawlc_pkg::ACT_C2P, it.word_address, 1,
				line_dat[ln * sawlc_pkg::MAX_BLOCK_WORDS + off], 1);
		end else begin
			line_dat[ln * sawlc_pkg::MAX_BLOCK_WORDS + off] = it.store_data;
			line_drt[ln] = 1;
			push_report(sawlc_pkg::ACT_P2C, it.word_address, 1, 0, 1);
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// one access transaction; valid stays high into the next call when no gap
	task automatic send_access(logic [1:0] kind, logic [15:0] addr, logic [31:0] dat);
		sawlc_pkg::in_t it;
		int gap;
		it.kind = kind;
		it.word_address = addr;
		it.store_data = dat;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		predict_access(it);
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (report_q.size() != 0) @(posedge clk);
		// preloads and ignored kinds may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		apply_cfg(idx, val);
		@(posedge clk);
	endtask

	task automatic set_geometry(int unsigned lb, int unsigned ls, int unsigned w);
		wait_idle();
		// shrink first so every step stays within the line budget
		write_cfg(sawlc_pkg::CFG_WAYS, 7'd1);
		write_cfg(sawlc_pkg::CFG_LOG2_SETS, ls[6:0]);
		write_cfg(sawlc_pkg::CFG_LOG2_BLOCK_WORDS, lb[6:0]);
		write_cfg(sawlc_pkg::CFG_WAYS, w[6:0]);
	endtask

	task automatic test_directed();
		send_access(sawlc_pkg::KIND_LOAD, 16'h0000, 32'h0);
		send_access(sawlc_pkg::KIND_STORE, 16'h0000, 32'h7FFFFFFF);
		send_access(sawlc_pkg::KIND_LOAD, 16'h0000, 32'h0);
		send_access(sawlc_pkg::KIND_PRELOAD, 16'hFFFF, 32'h80000000);
		send_access(sawlc_pkg::KIND_LOAD, 16'hFFFF, 32'h0);
		send_access(sawlc_pkg::KIND_STORE, 16'hFFFF, 32'hFFFFFFFF);
		send_access(sawlc_pkg::KIND_STORE, 16'h5555, 32'hA5A5A5A5);
		send_access(sawlc_pkg::KIND_LOAD, 16'hFFFF, 32'h0);
		send_access(2'd3, 16'hAAAA, 32'h12345678);
		send_access(sawlc_pkg::KIND_LOAD, 16'hAAAA, 32'h0);
		send_access(sawlc_pkg::KIND_PRELOAD, 16'h0000, 32'h0);
		send_access(sawlc_pkg::KIND_LOAD, 16'h0000, 32'hFFFFFFFF);
	endtask

	task automatic test_bad_config();
		wait_idle();
		write_cfg(sawlc_pkg::CFG_WAYS, 7'd0);
		write_cfg(sawlc_pkg::CFG_WAYS, 7'd100);
		write_cfg(sawlc_pkg::CFG_WAYS, 7'd127);
		write_cfg(sawlc_pkg::CFG_LOG2_BLOCK_WORDS, 7'd5);
		write_cfg(sawlc_pkg::CFG_LOG2_BLOCK_WORDS, 7'h7F);
		write_cfg(sawlc_pkg::CFG_LOG2_SETS, 7'd7);
		write_cfg(2'd3, 7'h7F);
		write_cfg(sawlc_pkg::CFG_LOG2_SETS, 7'd6);
		write_cfg(sawlc_pkg::CFG_WAYS, 7'd2);
		send_access(sawlc_pkg::KIND_LOAD, 16'h00C3, 32'h0);
		send_access(sawlc_pkg::KIND_STORE, 16'h00C3, 32'h0BADF00D);
		send_access(sawlc_pkg::KIND_LOAD, 16'h10C3, 32'h0);
		send_access(sawlc_pkg::KIND_LOAD, 16'h00C3, 32'h0);
	endtask

	task automatic test_random(int n, bit [15:0] span);
		bit [15:0] base, addr;
		int r;
		base = 16'($urandom());
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0) addr = 16'($urandom());
			else addr = 16'(base + $urandom_range(0, span));
			if (r < 45) send_access(sawlc_pkg::KIND_LOAD, addr, $urandom());
			else if (r < 85) send_access(sawlc_pkg::KIND_STORE, addr, $urandom());
			else if (r < 95) send_access(sawlc_pkg::KIND_PRELOAD, addr, $urandom());
			else send_access(2'd3, addr, $urandom());
		end
	endtask

	// output stall: runs of free flow and stall bursts, mostly short
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 3) == 0) begin
			out_stall <= ~out_stall;
			stall_left <= out_stall ? $urandom_range(5, 40)
				: ($urandom_range(0, 9) == 0 ? $urandom_range(20, 80) : $urandom_range(0, 3));
		end
	end

	// outputs are stable at the falling edge; the transaction lands on the next rising edge
	always @(negedge clk) begin
		sawlc_pkg::out_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (report_q.size() == 0) begin
				$error("unexpected transaction: %p", out_data);
				errors++;
			end else begin
				exp_r = report_q.pop_front();
				if (out_data.action !== exp_r.action) begin
					$error("action exp %0d got %0d", exp_r.action, out_data.action);
					errors++;
				end
				if (out_data.start_address !== exp_r.start_address) begin
					$error("start_address exp %h got %h", exp_r.start_address,
						out_data.start_address);
					errors++;
				end
				if (out_data.word_count !== exp_r.word_count) begin
					$error("word_count exp %0d got %0d", exp_r.word_count, out_data.word_count);
					errors++;
				end
				if (out_data.load_data !== exp_r.load_data) begin
					$error("load_data exp %h got %h", exp_r.load_data, out_data.load_data);
					errors++;
				end
				if (out_data.last !== exp_r.last) begin
					$error("last exp %0d got %0d", exp_r.last, out_data.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		blk_log2 = 0;
		set_log2 = 0;
		n_ways = 1;
		invalidate_lines();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_bad_config();
		set_geometry(2, 2, 4);
		test_random(25, 16'h00FF);
		set_geometry(4, 0, 64);
		test_random(20, 16'h07FF);
		set_geometry(0, 6, 1);
		test_random(20, 16'h00FF);
		set_geometry(1, 3, 8);
		test_random(20, 16'h01FF);
		set_geometry(0, 0, 1);
		test_random(15, 16'h0007);
		wait_idle();
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
